[src/vtp_pkg.sv]
// Shared constants for the vertex transform block: fixed-point formats,
// datapath widths, pipeline latencies and configuration register indexes.
// No dependencies.
package vtp_pkg;

  localparam int COEFF_FRAC_BITS  = 12;
  localparam int VERTEX_FRAC_BITS = 16;

  localparam int COEFF_W = 16;
  localparam int VERT_W  = 32;
  localparam int ROW_W   = 4 * COEFF_W;
  localparam int PROD_W  = COEFF_W + VERT_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int R_W     = ACC_W - COEFF_FRAC_BITS;
  localparam int QW      = VERT_W;

  localparam int DOT_LAT = 2;
  localparam int DIV_LAT = QW + 2;
  localparam int LAT     = DOT_LAT + DIV_LAT;

  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] REG_ROW0    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_ROW1    = 3'd1;
  localparam logic [CFG_AW-1:0] REG_ROW2    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_ROW3    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_PROJECT = 3'd4;

  localparam logic [ROW_W-1:0] ROW0_RST = 64'h0000_0000_0000_1000;
  localparam logic [ROW_W-1:0] ROW1_RST = 64'h0000_0000_1000_0000;
  localparam logic [ROW_W-1:0] ROW2_RST = 64'h0000_1000_0000_0000;
  localparam logic [ROW_W-1:0] ROW3_RST = 64'h1000_0000_0000_0000;

endpackage

[src/vertex_transform_project.sv]
// Top level of the homogeneous vertex transform with perspective divide.
// Depends on vtp_pkg, vtp_dot_lane and vtp_div_lane.
//
// The block takes one vertex every clock cycle (busy_o is never high) and
// delivers each result as a one-cycle done_o beat; the receiver cannot
// stall it. Each vertex passes through the two-stage multiply and sum of the
// four row lanes, then through the divider pipeline of the four result lanes,
// 32 stages with one quotient bit per stage; the w lane does not divide.
module vertex_transform_project import vtp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic signed [VERT_W-1:0] in_x_i,
  input  logic signed [VERT_W-1:0] in_y_i,
  input  logic signed [VERT_W-1:0] in_z_i,
  input  logic signed [VERT_W-1:0] in_w_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_AW-1:0]        cfg_addr_i,
  input  logic [ROW_W-1:0]         cfg_wdata_i,
  output logic                     done_o,
  output logic signed [VERT_W-1:0] out_x_o,
  output logic signed [VERT_W-1:0] out_y_o,
  output logic signed [VERT_W-1:0] out_z_o,
  output logic signed [VERT_W-1:0] out_w_o,
  output logic                     w_was_zero_o,
  output logic                     saturated_o
);

  logic [ROW_W-1:0] row_q [4];
  logic             proj_q;

  logic signed [R_W-1:0] r [4];
  logic [VERT_W-1:0]     res [4];
  logic [3:0]            sat;
  logic                  wzero;
  logic                  div_en;

  logic [LAT-1:0]     vld_q;
  logic [DIV_LAT-1:0] wz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= ROW0_RST;
      row_q[1] <= ROW1_RST;
      row_q[2] <= ROW2_RST;
      row_q[3] <= ROW3_RST;
      proj_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_ROW0:    row_q[0] <= cfg_wdata_i;
        REG_ROW1:    row_q[1] <= cfg_wdata_i;
        REG_ROW2:    row_q[2] <= cfg_wdata_i;
        REG_ROW3:    row_q[3] <= cfg_wdata_i;
        REG_PROJECT: proj_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_dot
    vtp_dot_lane u_dot (
      .clk_i (clk_i),
      .row_i (row_q[i]),
      .x_i   (in_x_i),
      .y_i   (in_y_i),
      .z_i   (in_z_i),
      .w_i   (in_w_i),
      .r_o   (r[i])
    );
  end

  assign wzero  = proj_q && (r[3] == '0);
  assign div_en = proj_q && !wzero;

  for (genvar i = 0; i < 4; i++) begin : g_div
    vtp_div_lane u_div (
      .clk_i    (clk_i),
      .num_i    (r[i]),
      .den_i    (r[3]),
      .div_en_i ((i < 3) ? div_en : 1'b0),
      .res_o    (res[i]),
      .sat_o    (sat[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    wz_q <= {wz_q[DIV_LAT-2:0], wzero};
  end

  assign busy_o       = 1'b0;
  assign done_o       = vld_q[LAT-1];
  assign out_x_o      = res[0];
  assign out_y_o      = res[1];
  assign out_z_o      = res[2];
  assign out_w_o      = res[3];
  assign w_was_zero_o = vld_q[LAT-1] && wz_q[DIV_LAT-1];
  assign saturated_o  = |sat;

  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LAT))
    else $error("result beat without a vertex accepted LAT cycles earlier");

  a_wzero_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    w_was_zero_o |-> done_o)
    else $error("zero-w flag raised outside a result beat");

  a_wzero_means_w_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    w_was_zero_o |-> (out_w_o == '0))
    else $error("zero-w flag with nonzero transformed w");

endmodule

[src/vtp_dot_lane.sv]
// One matrix row times the vertex: four multipliers, then a rounded sum.
// Depends on vtp_pkg.
module vtp_dot_lane import vtp_pkg::*; (
  input  logic                     clk_i,
  input  logic [ROW_W-1:0]         row_i,
  input  logic signed [VERT_W-1:0] x_i,
  input  logic signed [VERT_W-1:0] y_i,
  input  logic signed [VERT_W-1:0] z_i,
  input  logic signed [VERT_W-1:0] w_i,
  output logic signed [R_W-1:0]    r_o
);

  logic signed [PROD_W-1:0] prod_d [4];
  logic signed [PROD_W-1:0] prod_q [4];
  logic signed [VERT_W-1:0] vec [4];
  logic signed [ACC_W-1:0]  acc;
  logic signed [R_W-1:0]    r_q;

  assign vec[0] = x_i;
  assign vec[1] = y_i;
  assign vec[2] = z_i;
  assign vec[3] = w_i;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      prod_d[j] = $signed(row_i[COEFF_W*j +: COEFF_W]) * vec[j];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 4; j++) begin
      prod_q[j] <= prod_d[j];
    end
    r_q <= acc[ACC_W-1:COEFF_FRAC_BITS];
  end

  always_comb begin
    acc = ACC_W'(prod_q[0]) + ACC_W'(prod_q[1]) + ACC_W'(prod_q[2]) + ACC_W'(prod_q[3])
        + (ACC_W'(1) <<< (COEFF_FRAC_BITS - 1));
  end

  assign r_o = r_q;

endmodule

[src/vtp_div_lane.sv]
// One result lane: a pipelined restoring divider, one quotient bit per stage,
// followed by the clamp to 32 bits. Depends on vtp_pkg.
module vtp_div_lane import vtp_pkg::*; (
  input  logic                     clk_i,
  input  logic signed [R_W-1:0]    num_i,
  input  logic signed [R_W-1:0]    den_i,
  input  logic                     div_en_i,
  output logic [VERT_W-1:0]        res_o,
  output logic                     sat_o
);

  localparam int NN_W = R_W + VERTEX_FRAC_BITS;
  localparam int PADW = QW - VERTEX_FRAC_BITS;

  logic [R_W-1:0]  n_mag;
  logic [R_W-1:0]  d_mag;
  logic [NN_W-1:0] nn;
  logic            ovf;

  logic [R_W-1:0]        rem_q  [QW+1];
  logic [QW-1:0]         feed_q [QW+1];
  logic [QW-1:0]         quo_q  [QW+1];
  logic [R_W-1:0]        dv_q   [QW+1];
  logic                  neg_q  [QW+1];
  logic                  ovf_q  [QW+1];
  logic                  div_q  [QW+1];
  logic signed [R_W-1:0] num_q  [QW+1];

  logic [VERT_W-1:0] res_d, res_q;
  logic              sat_d, sat_q;

  always_comb begin
    n_mag = num_i[R_W-1] ? R_W'(-num_i) : R_W'(num_i);
    d_mag = den_i[R_W-1] ? R_W'(-den_i) : R_W'(den_i);
    nn    = {n_mag, {VERTEX_FRAC_BITS{1'b0}}};
    ovf   = {{PADW{1'b0}}, n_mag} >= {d_mag, {PADW{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= {{PADW{1'b0}}, nn[NN_W-1:QW]};
    feed_q[0] <= nn[QW-1:0];
    quo_q[0]  <= '0;
    dv_q[0]   <= d_mag;
    neg_q[0]  <= num_i[R_W-1] ^ den_i[R_W-1];
    ovf_q[0]  <= ovf;
    div_q[0]  <= div_en_i;
    num_q[0]  <= num_i;
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [R_W:0]   trial;
    logic           ge;
    logic [R_W-1:0] rem_d;

    always_comb begin
      trial = {rem_q[k], feed_q[k][QW-1]};
      ge    = trial >= {1'b0, dv_q[k]};
      rem_d = ge ? R_W'(trial - {1'b0, dv_q[k]}) : trial[R_W-1:0];
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1]  <= rem_d;
      feed_q[k+1] <= {feed_q[k][QW-2:0], 1'b0};
      quo_q[k+1]  <= {quo_q[k][QW-2:0], ge};
      dv_q[k+1]   <= dv_q[k];
      neg_q[k+1]  <= neg_q[k];
      ovf_q[k+1]  <= ovf_q[k];
      div_q[k+1]  <= div_q[k];
      num_q[k+1]  <= num_q[k];
    end
  end

  always_comb begin
    logic [QW-1:0]         q;
    logic signed [R_W-1:0] nv;
    logic [R_W-VERT_W:0]   top;
    q     = quo_q[QW];
    nv    = num_q[QW];
    top   = nv[R_W-1:VERT_W-1];
    sat_d = 1'b0;
    if (div_q[QW]) begin
      if (ovf_q[QW]) begin
        sat_d = 1'b1;
        res_d = neg_q[QW] ? {1'b1, {(VERT_W-1){1'b0}}} : {1'b0, {(VERT_W-1){1'b1}}};
      end else if (neg_q[QW]) begin
        if (q > {1'b1, {(QW-1){1'b0}}}) begin
          sat_d = 1'b1;
          res_d = {1'b1, {(VERT_W-1){1'b0}}};
        end else begin
          res_d = VERT_W'(-q);
        end
      end else if (q[QW-1]) begin
        sat_d = 1'b1;
        res_d = {1'b0, {(VERT_W-1){1'b1}}};
      end else begin
        res_d = VERT_W'(q);
      end
    end else if (!((&top) || !(|top))) begin
      sat_d = 1'b1;
      res_d = nv[R_W-1] ? {1'b1, {(VERT_W-1){1'b0}}} : {1'b0, {(VERT_W-1){1'b1}}};
    end else begin
      res_d = nv[VERT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    sat_q <= sat_d;
  end

  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule

[verif/vertex_transform_project_tb.sv]
// Self-checking testbench for vertex_transform_project: matrix transform, divide and clamp flags.
// A queue-fed driver and a result monitor are checked against an in-bench predictor.
// Depends on vtp_pkg and the vertex_transform_project RTL.
`timescale 1ns / 100ps

module vertex_transform_project_tb;
  import vtp_pkg::*;

  typedef enum logic [1:0] {BEAT_VERTEX, BEAT_CONFIG, BEAT_DRAIN} beat_kind_e;

  typedef struct {
    beat_kind_e              kind;
    logic [VERT_W-1:0]       x, y, z, w;
    logic [CFG_AW-1:0]       addr;
    logic [ROW_W-1:0]        data;
    int                      gap;
  } stim_beat_t;

  typedef struct {
    logic [VERT_W-1:0] x, y, z, w;
    logic              w_zero;
    logic              sat;
  } xform_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic signed [VERT_W-1:0] in_x_i = '0, in_y_i = '0, in_z_i = '0, in_w_i = '0;
  logic cfg_we_i = 1'b0;
  logic [CFG_AW-1:0] cfg_addr_i = '0;
  logic [ROW_W-1:0] cfg_wdata_i = '0;
  logic busy_o, done_o, w_was_zero_o, saturated_o;
  logic signed [VERT_W-1:0] out_x_o, out_y_o, out_z_o, out_w_o;

  stim_beat_t    vertex_queue[$];
  xform_result_t expected_results[$];
  logic [ROW_W-1:0] matrix_rows[4];
  logic project_on;
  int gap_left = 0;
  int mismatches = 0;
  bit no_idle = 0;

  vertex_transform_project DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .in_x_i(in_x_i), .in_y_i(in_y_i), .in_z_i(in_z_i), .in_w_i(in_w_i),
    .cfg_we_i(cfg_we_i), .cfg_addr_i(cfg_addr_i), .cfg_wdata_i(cfg_wdata_i),
    .done_o(done_o), .out_x_o(out_x_o), .out_y_o(out_y_o), .out_z_o(out_z_o),
    .out_w_o(out_w_o), .w_was_zero_o(w_was_zero_o), .saturated_o(saturated_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic longint row_product(logic [ROW_W-1:0] row, longint v[4]);
    longint acc;
    acc = 0;
    for (int j = 0; j < 4; j++) begin
      acc += longint'($signed(row[16*j +: 16])) * v[j];
    end
    acc += longint'(1) << (COEFF_FRAC_BITS - 1);
    return acc >>> COEFF_FRAC_BITS;
  endfunction

  function automatic logic [VERT_W-1:0] clamp_to_word(longint v, inout logic sat);
    if (v > longint'(32'sh7FFF_FFFF)) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -longint'(64'sd2147483648)) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic [VERT_W-1:0] fixed_quotient(longint num, longint den,
                                                       inout logic sat);
    logic neg;
    longint unsigned n, d, qi, rem, frac, mag;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    qi = n / d;
    rem = n % d;
    frac = 0;
    if (qi > (longint'(1) << 32)) begin
      sat = 1'b1;
      return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    for (int i = 0; i < VERTEX_FRAC_BITS; i++) begin
      rem = rem << 1;
      frac = frac << 1;
      if (rem >= d) begin
        rem -= d;
        frac |= 1;
      end
    end
    mag = (qi << VERTEX_FRAC_BITS) | frac;
    if (mag > (longint'(1) << 40)) mag = longint'(1) << 40;
    return clamp_to_word(neg ? -longint'(mag) : longint'(mag), sat);
  endfunction

  function automatic xform_result_t transform_vertex(stim_beat_t b);
    xform_result_t res;
    longint v[4];
    longint r[4];
    logic [VERT_W-1:0] o[3];
    logic sat;
    sat = 1'b0;
    v[0] = longint'($signed(b.x));
    v[1] = longint'($signed(b.y));
    v[2] = longint'($signed(b.z));
    v[3] = longint'($signed(b.w));
    for (int i = 0; i < 4; i++) r[i] = row_product(matrix_rows[i], v);
    for (int i = 0; i < 3; i++) begin
      if (project_on && r[3] != 0) o[i] = fixed_quotient(r[i], r[3], sat);
      else o[i] = clamp_to_word(r[i], sat);
    end
    res.x = o[0];
    res.y = o[1];
    res.z = o[2];
    res.w = clamp_to_word(r[3], sat);
    res.w_zero = project_on && (r[3] == 0);
    res.sat = sat;
    return res;
  endfunction

  // Driver: one vertex per beat, config writes only once the pipeline has emptied.
  always @(posedge clk_i) begin
    logic nxt_start, nxt_we;
    stim_beat_t cur;
    nxt_start = 1'b0;
    nxt_we = 1'b0;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_ROW0:    matrix_rows[0] = cfg_wdata_i;
          REG_ROW1:    matrix_rows[1] = cfg_wdata_i;
          REG_ROW2:    matrix_rows[2] = cfg_wdata_i;
          REG_ROW3:    matrix_rows[3] = cfg_wdata_i;
          REG_PROJECT: project_on = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (start_i && !busy_o) begin
        cur.kind = BEAT_VERTEX;
        cur.x = in_x_i;
        cur.y = in_y_i;
        cur.z = in_z_i;
        cur.w = in_w_i;
        expected_results.push_back(transform_vertex(cur));
      end
      if (start_i && busy_o) begin
        nxt_start = 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (vertex_queue.size() > 0 && vertex_queue[0].kind == BEAT_VERTEX) begin
        cur = vertex_queue.pop_front();
        in_x_i <= cur.x;
        in_y_i <= cur.y;
        in_z_i <= cur.z;
        in_w_i <= cur.w;
        gap_left <= cur.gap;
        nxt_start = 1'b1;
      end else if (vertex_queue.size() > 0 && !start_i && !cfg_we_i &&
                   expected_results.size() == 0) begin
        cur = vertex_queue.pop_front();
        if (cur.kind == BEAT_CONFIG) begin
          cfg_addr_i <= cur.addr;
          cfg_wdata_i <= cur.data;
          nxt_we = 1'b1;
        end
      end
      start_i <= nxt_start;
      cfg_we_i <= nxt_we;
    end
  end

  task automatic note_mismatch(string what, logic [VERT_W-1:0] want, logic [VERT_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h actual %h", what, want, got);
  endtask

  always @(posedge clk_i) begin
    xform_result_t exp_r;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        note_mismatch("unexpected result beat", '0, out_x_o);
      end else begin
        exp_r = expected_results.pop_front();
        if (out_x_o !== exp_r.x) note_mismatch("out_x", exp_r.x, out_x_o);
        if (out_y_o !== exp_r.y) note_mismatch("out_y", exp_r.y, out_y_o);
        if (out_z_o !== exp_r.z) note_mismatch("out_z", exp_r.z, out_z_o);
        if (out_w_o !== exp_r.w) note_mismatch("out_w", exp_r.w, out_w_o);
        if (w_was_zero_o !== exp_r.w_zero)
          note_mismatch("w_was_zero", exp_r.w_zero, w_was_zero_o);
        if (saturated_o !== exp_r.sat) note_mismatch("saturated", exp_r.sat, saturated_o);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic add_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] w);
    stim_beat_t b;
    b.kind = BEAT_VERTEX;
    b.x = x;
    b.y = y;
    b.z = z;
    b.w = w;
    b.gap = pick_gap();
    vertex_queue.push_back(b);
  endtask

  task automatic add_config(logic [CFG_AW-1:0] addr, logic [ROW_W-1:0] data);
    stim_beat_t b;
    b.kind = BEAT_CONFIG;
    b.addr = addr;
    b.data = data;
    b.gap = 0;
    vertex_queue.push_back(b);
  endtask

  task automatic add_drain();
    stim_beat_t b;
    b.kind = BEAT_DRAIN;
    b.gap = 0;
    vertex_queue.push_back(b);
  endtask

  function automatic logic [ROW_W-1:0] pick_row(int idx);
    logic [ROW_W-1:0] row;
    case ($urandom_range(0, 9))
      0: row = '1;
      1: row = 64'h8000_8000_8000_8000;
      2: row = 64'h7FFF_7FFF_7FFF_7FFF;
      3: row = '0;
      4, 5: row = {$urandom, $urandom};
      default: begin
        row = '0;
        for (int j = 0; j < 4; j++) row[16*j +: 16] = 16'($urandom_range(0, 1023)) - 16'd512;
        row[16*idx +: 16] = 16'h1000 + 16'($urandom_range(0, 2047)) - 16'd1024;
      end
    endcase
    return row;
  endfunction

  function automatic logic [31:0] pick_component(bit is_w);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return 32'($urandom_range(0, 255)) - 32'd128;
      default: return is_w ? 32'($urandom_range(32'h8000, 32'h30000))
                           : 32'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000;
    endcase
  endfunction

  initial begin
    matrix_rows[0] = ROW0_RST;
    matrix_rows[1] = ROW1_RST;
    matrix_rows[2] = ROW2_RST;
    matrix_rows[3] = ROW3_RST;
    project_on = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset matrix is the identity, projection on.
    add_vertex(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000);
    add_vertex(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0000_0000);
    add_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
    add_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_0000);
    add_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000);
    add_vertex(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_8000, 32'h7FFF_FFFF);
    add_vertex(32'h0003_0000, 32'hFFFD_0000, 32'h0001_0000, 32'h0000_0003);
    add_drain();
    add_config(REG_PROJECT, 64'hFFFF_FFFF_FFFF_FFFE);
    add_config(REG_ROW0, 64'h7FFF_7FFF_7FFF_7FFF);
    add_config(REG_ROW3, 64'h8000_8000_8000_8000);
    add_config(3'($urandom_range(5, 7)), '1);
    add_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_vertex(32'h0000_0800, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    add_vertex(32'hFFFF_F800, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
    add_config(REG_PROJECT, 64'd1);
    add_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    add_vertex(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    add_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);

    for (int phase = 0; phase < 12; phase++) begin
      for (int i = 0; i < 4; i++) add_config(3'(i), pick_row(i));
      add_config(REG_PROJECT, {$urandom, $urandom});
      if (phase == 3) add_config(REG_ROW3, '0);
      no_idle = (phase % 4 == 1);
      for (int n = 0; n < 135; n++) begin
        if (n == 70) add_drain();
        if ($urandom_range(0, 9) == 0)
          add_vertex($urandom, $urandom, $urandom, $urandom);
        else
          add_vertex(pick_component(0), pick_component(0), pick_component(0),
                     pick_component(1));
      end
    end

    while (vertex_queue.size() > 0 || start_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (LAT + 10) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("vertex_transform_project_tb passed");
    end else begin
      $display("vertex_transform_project_tb failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("vertex_transform_project_tb failed");
    $finish;
  end

endmodule

[filelist.f]
src/vtp_pkg.sv
src/vtp_dot_lane.sv
src/vtp_div_lane.sv
src/vertex_transform_project.sv
verif/vertex_transform_project_tb.sv
